>>> rtl/lcafr_pkg.sv
// ----------------------------------------------------------------------------
// lcafr_pkg: shared types and constants for the load-cell reader/framer
// Sequencer phases, the job record passed from front to back, frame constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lcafr_pkg;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_HIGH   = 3'd2,
    PH_LOW    = 3'd3,
    PH_XHIGH  = 3'd4,
    PH_XLOW   = 3'd5
  } phase_t;

  // Configuration register indexes
  localparam logic REG_SETTLE = 1'b0;
  localparam logic REG_HALF   = 1'b1;

  localparam logic [7:0] SETTLE_RESET = 8'd5;
  localparam logic [7:0] HALF_RESET   = 8'd2;

  // Frame layout
  localparam logic [7:0] FRAME_HEADER = 8'hAA;
  localparam int         FRAME_BEATS  = 6;
  localparam int         BEAT_W       = 3;

  typedef enum logic [BEAT_W-1:0] {
    BT_HEADER = 3'd0,
    BT_B3     = 3'd1,
    BT_B2     = 3'd2,
    BT_B1     = 3'd3,
    BT_B0     = 3'd4,
    BT_SUM    = 3'd5
  } beat_t;

  // Job handed from the sequencer to the frame emitter
  typedef struct packed {
    logic        frame;    // completing tick: six frame beats
    logic        clk_lvl;  // serial clock level after this tick
    logic [31:0] sample;   // held result, sign-extended
  } job_t;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

endpackage

`default_nettype wire

>>> rtl/lcafr_front.sv
// ----------------------------------------------------------------------------
// lcafr_front: tick sequencer
// Detects the start edge, times settle and clock phases, shifts in the data
// line and posts one job per accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module lcafr_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              tick_valid,
  input  wire logic              data_line,
  output logic                   tick_ready,
  input  wire logic [7:0]        settle_ticks,
  input  wire logic [7:0]        half_period_ticks,
  output logic                   job_push,
  output lcafr_pkg::job_t        job,
  input  wire logic              job_ready
);

  localparam int PCNT_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [PCNT_W-1:0] PULSES = PCNT_W'(SAMPLE_BITS);

  lcafr_pkg::phase_t phase_r, phase_nxt;
  logic                   prev_r, prev_nxt;
  logic [7:0]             tick_r, tick_nxt;
  logic [PCNT_W-1:0]      pulse_r, pulse_nxt;
  logic [SAMPLE_BITS-1:0] shift_r, shift_nxt;
  logic [31:0]            held_r, held_nxt;

  logic                   accept;
  logic [7:0]             half;
  logic [8:0]             tick_inc;
  logic                   settle_done;
  logic                   half_done;
  logic [PCNT_W-1:0]      pulse_inc;
  logic signed [SAMPLE_BITS-1:0] shift_next_s;

  assign tick_ready  = job_ready;
  assign accept      = tick_valid & job_ready;
  assign half        = (half_period_ticks == 8'd0) ? 8'd1 : half_period_ticks;
  assign tick_inc    = {1'b0, tick_r} + 9'd1;
  assign settle_done = tick_inc >= {1'b0, settle_ticks};
  assign half_done   = tick_inc >= {1'b0, half};
  assign pulse_inc   = pulse_r + PCNT_W'(1);
  assign shift_next_s = {shift_r[SAMPLE_BITS-2:0], data_line};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      lcafr_pkg::PH_IDLE: begin
        if (prev_r && !data_line) begin
          phase_nxt = (settle_ticks != 8'd0) ? lcafr_pkg::PH_SETTLE : lcafr_pkg::PH_HIGH;
        end
      end
      lcafr_pkg::PH_SETTLE: begin
        if (settle_done) phase_nxt = lcafr_pkg::PH_HIGH;
      end
      lcafr_pkg::PH_HIGH: begin
        if (half_done) phase_nxt = lcafr_pkg::PH_LOW;
      end
      lcafr_pkg::PH_XHIGH: begin
        if (half_done) phase_nxt = lcafr_pkg::PH_XLOW;
      end
      lcafr_pkg::PH_LOW: begin
        if (half_done) begin
          phase_nxt = (pulse_inc >= PULSES) ? lcafr_pkg::PH_XHIGH : lcafr_pkg::PH_HIGH;
        end
      end
      lcafr_pkg::PH_XLOW: begin
        if (half_done) phase_nxt = lcafr_pkg::PH_IDLE;
      end
      default: phase_nxt = lcafr_pkg::PH_IDLE;
    endcase
  end

  // Counters, shifter and job
  always_comb begin
    prev_nxt  = data_line;
    tick_nxt  = tick_r;
    pulse_nxt = pulse_r;
    shift_nxt = shift_r;
    held_nxt  = held_r;
    job.frame   = 1'b0;
    job.clk_lvl = 1'b0;
    unique case (phase_r) inside
      lcafr_pkg::PH_IDLE: begin
        if (prev_r && !data_line) begin
          tick_nxt  = 8'd0;
          pulse_nxt = '0;
          shift_nxt = '0;
        end
      end
      lcafr_pkg::PH_SETTLE: begin
        tick_nxt = settle_done ? 8'd0 : tick_inc[7:0];
      end
      lcafr_pkg::PH_HIGH, lcafr_pkg::PH_XHIGH: begin
        job.clk_lvl = 1'b1;
        tick_nxt    = half_done ? 8'd0 : tick_inc[7:0];
      end
      lcafr_pkg::PH_LOW: begin
        tick_nxt = half_done ? 8'd0 : tick_inc[7:0];
        if (half_done) begin
          shift_nxt = shift_next_s;
          pulse_nxt = pulse_inc;
        end
      end
      lcafr_pkg::PH_XLOW: begin
        tick_nxt = half_done ? 8'd0 : tick_inc[7:0];
        if (half_done) begin
          held_nxt  = 32'(signed'(shift_r));
          pulse_nxt = '0;
          job.frame = 1'b1;
        end
      end
      default: tick_nxt = 8'd0;
    endcase
    job.sample = held_nxt;
  end

  assign job_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lcafr_pkg::PH_IDLE;
      prev_r  <= 1'b1;
      tick_r  <= 8'd0;
      pulse_r <= '0;
      shift_r <= '0;
      held_r  <= 32'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      tick_r  <= tick_nxt;
      pulse_r <= pulse_nxt;
      shift_r <= shift_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lcafr_queue.sv
// ----------------------------------------------------------------------------
// lcafr_queue: two-entry job queue
// Decouples the tick sequencer from the frame emitter; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcafr_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lcafr_pkg::job_t   push_data,
  output logic                   not_full,
  input  wire logic              pop,
  output logic                   not_empty,
  output lcafr_pkg::job_t        head
);

  lcafr_pkg::job_t mem_r [lcafr_pkg::QDEPTH];
  logic [lcafr_pkg::QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [lcafr_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign not_full  = cnt_r != lcafr_pkg::QCNT_W'(lcafr_pkg::QDEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push & not_full;
  assign do_pop    = pop & not_empty;
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + lcafr_pkg::QCNT_W'(do_push) - lcafr_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

`default_nettype wire

>>> rtl/lcafr_back.sv
// ----------------------------------------------------------------------------
// lcafr_back: result emitter
// Expands each job into one status beat or a six-byte frame, into an output
// register that takes a new beat whenever the old one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module lcafr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  input  wire lcafr_pkg::job_t   job,
  output logic                   job_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   clock_line,
  output logic                   byte_valid,
  output logic [7:0]             frame_byte,
  output logic                   frame_last,
  output logic [23:0]            latest_sample
);

  lcafr_pkg::beat_t beat_r, beat_nxt;
  logic        valid_r, valid_nxt;
  logic        clk_r, bvalid_r, last_r;
  logic [7:0]  byte_r;
  logic [23:0] sample_r;

  logic        load;
  logic        job_done;
  logic [7:0]  byte_sel;
  logic [7:0]  checksum;

  assign load     = !valid_r || out_ready;
  assign job_pop  = load && job_valid;
  assign job_done = !job.frame || (beat_r == lcafr_pkg::BT_SUM);
  assign checksum = job.sample[31:24] + job.sample[23:16] + job.sample[15:8]
                  + job.sample[7:0];

  always_comb begin
    case (beat_r)
      lcafr_pkg::BT_HEADER: byte_sel = lcafr_pkg::FRAME_HEADER;
      lcafr_pkg::BT_B3:     byte_sel = job.sample[31:24];
      lcafr_pkg::BT_B2:     byte_sel = job.sample[23:16];
      lcafr_pkg::BT_B1:     byte_sel = job.sample[15:8];
      lcafr_pkg::BT_B0:     byte_sel = job.sample[7:0];
      lcafr_pkg::BT_SUM:    byte_sel = checksum;
      default:              byte_sel = 8'd0;
    endcase
  end

  always_comb begin
    beat_nxt  = beat_r;
    valid_nxt = valid_r;
    if (job_pop) begin
      valid_nxt = 1'b1;
      beat_nxt  = job_done ? lcafr_pkg::BT_HEADER
                           : lcafr_pkg::beat_t'(beat_r + 3'd1);
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // job_pop here means a beat is issued; the queue entry itself only leaves
  // on the final beat of its job (see top level).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= lcafr_pkg::BT_HEADER;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      clk_r    <= job.frame ? 1'b0 : job.clk_lvl;
      bvalid_r <= job.frame;
      byte_r   <= job.frame ? byte_sel : 8'd0;
      last_r   <= job.frame && (beat_r == lcafr_pkg::BT_SUM);
      sample_r <= job.sample[23:0];
    end
  end

  assign out_valid     = valid_r;
  assign clock_line    = clk_r;
  assign byte_valid    = bvalid_r;
  assign frame_byte    = byte_r;
  assign frame_last    = last_r;
  assign latest_sample = sample_r;

endmodule

`default_nettype wire

>>> rtl/load_cell_adc_reader_framer_core.sv
// ----------------------------------------------------------------------------
// load_cell_adc_reader_framer_core: load-cell converter reader and framer
// Serial read sequencer with a queued frame emitter on a stream interface.
// ----------------------------------------------------------------------------
// Each input request is one timing tick carrying the converter's data-line
// level; each tick produces one result request carrying the serial clock
// level to drive next. While idle, a high-to-low data-line edge starts a
// read: settle_ticks low ticks, then SAMPLE_BITS clock pulses of
// half_period_ticks high and half_period_ticks low (zero counts as one),
// sampling MSB first on the last low tick, then one extra pulse (channel A,
// gain 128). The tick ending that pulse yields six result requests instead
// of one: 0xAA, the sign-extended value as four big-endian bytes, and their
// byte sum mod 256 (tlast set). Throughput is one tick per clock while the
// job queue has room; the sequencer state updates on each accepted tick.
// On a completing tick the emitter issues the frame's six beats one by one,
// so the input side stalls while the two-entry job queue is full.
// Output is fully registered; a new tick is taken while a previous result
// still waits downstream.
// Configuration writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_adc_reader_framer_core #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tick input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] data_line, [7:1] zero
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [0] clock_line, [8:1] frame_byte,
                                       // [32:9] latest_sample, [39:33] zero
  output logic             out_tuser,  // byte_valid
  output logic             out_tlast,  // frame_last
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,   // 0 settle_ticks, 1 half_period_ticks
  input  wire logic [7:0]  cfg_wdata
);

  logic [7:0] settle_r, half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= lcafr_pkg::SETTLE_RESET;
      half_r   <= lcafr_pkg::HALF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lcafr_pkg::REG_SETTLE: settle_r <= cfg_wdata;
        lcafr_pkg::REG_HALF:   half_r   <= cfg_wdata;
      endcase
    end
  end

  lcafr_pkg::job_t push_job, head_job;
  logic push, q_not_full, q_not_empty, beat_issue, q_pop;
  logic last_beat;

  lcafr_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .tick_valid       (in_tvalid),
    .data_line        (in_tdata[0]),
    .tick_ready       (in_tready),
    .settle_ticks     (settle_r),
    .half_period_ticks(half_r),
    .job_push         (push),
    .job              (push_job),
    .job_ready        (q_not_full)
  );

  lcafr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_job),
    .not_full (q_not_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (head_job)
  );

  logic        clock_line, byte_valid, frame_last;
  logic [7:0]  frame_byte;
  logic [23:0] latest_sample;

  lcafr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (q_not_empty),
    .job          (head_job),
    .job_pop      (beat_issue),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .clock_line   (clock_line),
    .byte_valid   (byte_valid),
    .frame_byte   (frame_byte),
    .frame_last   (frame_last),
    .latest_sample(latest_sample)
  );

  logic u_back_last;
  lcafr_pkg::beat_t beat_track_r, beat_track_nxt;

  // A queue entry retires on the last beat of its job: the only beat of a
  // plain tick, or the checksum beat of a frame.
  always_comb begin
    last_beat = !head_job.frame;
    if (head_job.frame) begin
      last_beat = u_back_last;
    end
  end

  assign u_back_last = beat_track_r == lcafr_pkg::BT_SUM;
  assign q_pop       = beat_issue && last_beat;

  // Mirrors the emitter's beat counter to decide when to retire the entry.
  always_comb begin
    beat_track_nxt = beat_track_r;
    if (beat_issue) begin
      beat_track_nxt = last_beat ? lcafr_pkg::BT_HEADER
                                 : lcafr_pkg::beat_t'(beat_track_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_track_r <= lcafr_pkg::BT_HEADER;
    end else begin
      beat_track_r <= beat_track_nxt;
    end
  end

  assign out_tdata = {7'd0, latest_sample, frame_byte, clock_line};
  assign out_tuser = byte_valid;
  assign out_tlast = frame_last;

endmodule

`default_nettype wire
